FILE: design/gnms_pkg.sv
// Shared types and constants of the gradient non-maximum suppression block.
`timescale 1ns / 1ps
package gnms_pkg;
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = 13;
    localparam int CW         = 16;
    localparam int CFG_COLS_W = 11;
    localparam int CFG_ROWS_W = 13;
    localparam int CFG_W      = 13;
    localparam int MAG_W      = 15;
    localparam int G_W        = 16;
    localparam int OPD_W      = 17;
    localparam int PROD_W     = 33;
    localparam int SIDE_W     = 34;
    localparam int Q_DEPTH    = 8;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = Q_AW + 1;

    localparam logic [1:0] LBL_UNEXAMINED = 2'd0;
    localparam logic [1:0] LBL_NO_EDGE    = 2'd1;
    localparam logic [1:0] LBL_POSSIBLE   = 2'd2;

    localparam logic CFG_IDX_COLS = 1'b0;
    localparam logic CFG_IDX_ROWS = 1'b1;

    typedef struct packed {
        logic [MAG_W-1:0]      magnitude;
        logic signed [G_W-1:0] grad_x;
        logic signed [G_W-1:0] grad_y;
        logic                  pad;
    } t_gnms_in;

    typedef struct packed {
        logic [1:0] edge_label;
        logic       frame_end;
    } t_gnms_out;

    // classified word handed from front to back
    typedef struct packed {
        logic signed [OPD_W-1:0] a1;
        logic signed [OPD_W-1:0] b1;
        logic signed [OPD_W-1:0] a2;
        logic signed [OPD_W-1:0] b2;
        logic signed [G_W-1:0]   gx;
        logic signed [G_W-1:0]   gy;
        logic                    examine;
        logic                    zero;
        logic                    last;
    } t_gnms_op;
endpackage

FILE: design/gnms_front.sv
// Front: raster counters, line stores, 3x3 window and octant operand selection.
`timescale 1ns / 1ps
module gnms_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  gnms_pkg::t_gnms_in           i_in,
    input  logic [gnms_pkg::CFG_COLS_W-1:0] i_frame_cols,
    input  logic [gnms_pkg::CFG_ROWS_W-1:0] i_frame_rows,
    output logic                         o_push,
    output gnms_pkg::t_gnms_op           o_op
);
    import gnms_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [CW-1:0] cols_e, rows_e, col_x, row_x, orow, ocol;
    logic          ignore, go, live, emit, examine, last;
    logic [MAG_W-1:0]      mag;
    logic signed [G_W-1:0] gx, gy;

    logic [MAG_W-1:0]      m_up [MAX_COLS];
    logic [MAG_W-1:0]      m_ct [MAX_COLS];
    logic signed [G_W-1:0] m_gx [MAX_COLS];
    logic signed [G_W-1:0] m_gy [MAX_COLS];

    logic [MAG_W-1:0]      r_rd_up, r_rd_ct;
    logic signed [G_W-1:0] r_rd_gx, r_rd_gy;

    logic             r_s1_v, r_s1_emit, r_s1_exam, r_s1_last;
    logic [COL_W-1:0] r_s1_idx;
    logic [MAG_W-1:0] r_s1_mag;

    logic [MAG_W-1:0] r_wu [3];
    logic [MAG_W-1:0] r_wc [3];
    logic [MAG_W-1:0] r_wd [3];
    logic signed [G_W-1:0] r_gxd, r_gyd, r_cgx, r_cgy;
    logic r_s2_v, r_s2_exam, r_s2_last;

    always_comb begin
        cols_e = CW'(i_frame_cols);
        if (cols_e < CW'(3)) cols_e = CW'(3);
        if (cols_e > CW'(MAX_COLS)) cols_e = CW'(MAX_COLS);
        rows_e = CW'(i_frame_rows);
        if (rows_e < CW'(3)) rows_e = CW'(3);
        if (rows_e > CW'(MAX_ROWS)) rows_e = CW'(MAX_ROWS);
        col_x = CW'(r_col);
        row_x = CW'(r_row);
        ignore = i_in.pad && (r_row == '0) && (r_col == '0);
        go = i_fire && !ignore;
        live = !i_in.pad && (row_x < rows_e);
        mag = live ? i_in.magnitude : '0;
        gx = live ? i_in.grad_x : '0;
        gy = live ? i_in.grad_y : '0;
        emit = (row_x >= CW'(2)) || ((row_x == CW'(1)) && (r_col != '0));
        if (r_col != '0) begin
            orow = row_x - CW'(1);
            ocol = col_x - CW'(1);
        end else begin
            orow = row_x - CW'(2);
            ocol = cols_e - CW'(1);
        end
        examine = (orow >= CW'(1)) && (orow + CW'(3) <= rows_e)
               && (ocol >= CW'(1)) && (ocol + CW'(3) <= cols_e);
        last = emit && (orow + CW'(1) >= rows_e) && (ocol + CW'(1) >= cols_e);
        n_col = r_col;
        n_row = r_row;
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_x + CW'(1) >= cols_e) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (go) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read old entry, write new one; upper store takes the old center in the next cycle
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rd_up <= m_up[r_col];
            r_rd_ct <= m_ct[r_col];
            r_rd_gx <= m_gx[r_col];
            r_rd_gy <= m_gy[r_col];
            m_ct[r_col] <= mag;
            m_gx[r_col] <= gx;
            m_gy[r_col] <= gy;
        end
        if (r_s1_v) begin
            m_up[r_s1_idx] <= r_rd_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= go;
            r_s2_v <= r_s1_v && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_idx  <= r_col;
            r_s1_mag  <= mag;
            r_s1_emit <= emit;
            r_s1_exam <= examine;
            r_s1_last <= last;
        end
        if (r_s1_v) begin
            r_wu[0] <= r_wu[1];
            r_wc[0] <= r_wc[1];
            r_wd[0] <= r_wd[1];
            r_wu[1] <= r_wu[2];
            r_wc[1] <= r_wc[2];
            r_wd[1] <= r_wd[2];
            r_wu[2] <= r_rd_up;
            r_wc[2] <= r_rd_ct;
            r_wd[2] <= r_s1_mag;
            r_cgx <= r_gxd;
            r_cgy <= r_gyd;
            r_gxd <= r_rd_gx;
            r_gyd <= r_rd_gy;
            r_s2_exam <= r_s1_exam;
            r_s2_last <= r_s1_last;
        end
    end

    // octant selection on the window as it stands after the shift
    logic signed [OPD_W-1:0] u0, u1, u2, c0, c2, d0, d1, d2, m;
    logic signed [OPD_W-1:0] gx17, gy17;

    always_comb begin
        u0 = $signed({2'b00, r_wu[0]});
        u1 = $signed({2'b00, r_wu[1]});
        u2 = $signed({2'b00, r_wu[2]});
        c0 = $signed({2'b00, r_wc[0]});
        m  = $signed({2'b00, r_wc[1]});
        c2 = $signed({2'b00, r_wc[2]});
        d0 = $signed({2'b00, r_wd[0]});
        d1 = $signed({2'b00, r_wd[1]});
        d2 = $signed({2'b00, r_wd[2]});
        gx17 = $signed({r_cgx[G_W-1], r_cgx});
        gy17 = $signed({r_cgy[G_W-1], r_cgy});
        o_op.gx = r_cgx;
        o_op.gy = r_cgy;
        o_op.examine = r_s2_exam;
        o_op.zero = (r_wc[1] == '0);
        o_op.last = r_s2_last;
        if (!r_cgx[G_W-1]) begin
            if (!r_cgy[G_W-1]) begin
                if (gx17 >= gy17) begin
                    o_op.a1 = m - c0;   o_op.b1 = u0 - c0;
                    o_op.a2 = m - c2;   o_op.b2 = d2 - c2;
                end else begin
                    o_op.a1 = u1 - u0;  o_op.b1 = u1 - m;
                    o_op.a2 = d1 - d2;  o_op.b2 = d1 - m;
                end
            end else begin
                if (gx17 >= -gy17) begin
                    o_op.a1 = m - c0;   o_op.b1 = c0 - d0;
                    o_op.a2 = m - c2;   o_op.b2 = c2 - u2;
                end else begin
                    o_op.a1 = d1 - d0;  o_op.b1 = m - d1;
                    o_op.a2 = u1 - u2;  o_op.b2 = m - u1;
                end
            end
        end else begin
            if (!r_cgy[G_W-1]) begin
                if (-gx17 >= gy17) begin
                    o_op.a1 = c2 - m;   o_op.b1 = u2 - c2;
                    o_op.a2 = c0 - m;   o_op.b2 = d0 - c0;
                end else begin
                    o_op.a1 = u2 - u1;  o_op.b1 = u1 - m;
                    o_op.a2 = d0 - d1;  o_op.b2 = d1 - m;
                end
            end else begin
                if (gy17 > gx17) begin
                    o_op.a1 = c2 - m;   o_op.b1 = c2 - d2;
                    o_op.a2 = c0 - m;   o_op.b2 = c0 - u0;
                end else begin
                    o_op.a1 = d2 - d1;  o_op.b1 = m - d1;
                    o_op.a2 = u0 - u1;  o_op.b2 = m - u1;
                end
            end
        end
    end

    assign o_push = r_s2_v;
endmodule

FILE: design/gnms_queue.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
module gnms_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  gnms_pkg::t_gnms_op      i_op,
    input  logic                    i_pop,
    output logic                    o_valid,
    output gnms_pkg::t_gnms_op      o_op,
    output logic [gnms_pkg::Q_CW-1:0] o_count
);
    import gnms_pkg::*;

    t_gnms_op        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_AW'(1);
            if (i_pop)  r_rp <= r_rp + Q_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];
    assign o_count = r_cnt;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == Q_CW'(Q_DEPTH)) |-> !i_push || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue pop while empty");
    a_count_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != Q_CW'(Q_DEPTH)) |-> (Q_AW'(r_wp - r_rp) == r_cnt[Q_AW-1:0]))
        else $error("queue count and pointers disagree");
endmodule

FILE: design/gnms_back.sv
// Back: side-test products, sign decision and output register.
`timescale 1ns / 1ps
module gnms_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  gnms_pkg::t_gnms_op  i_op,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output gnms_pkg::t_gnms_out o_out
);
    import gnms_pkg::*;

    logic r_b_v, r_b_exam, r_b_zero, r_b_last;
    logic signed [PROD_W-1:0] r_pa1, r_pb1, r_pa2, r_pb2;
    logic      r_o_v;
    t_gnms_out r_o;
    logic      out_free, b_load;
    logic signed [SIDE_W-1:0] s1, s2;
    logic [1:0] label;

    assign out_free = !r_o_v || i_ready;
    assign b_load   = !r_b_v || out_free;
    assign o_pop    = i_q_valid && b_load;

    always_comb begin
        s1 = SIDE_W'(r_pb1) - SIDE_W'(r_pa1);
        s2 = SIDE_W'(r_pb2) - SIDE_W'(r_pa2);
        if (!r_b_exam) label = LBL_UNEXAMINED;
        else if (r_b_zero) label = LBL_NO_EDGE;
        else if (s1 > 0 || s2 >= 0) label = LBL_NO_EDGE;
        else label = LBL_POSSIBLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (b_load) r_b_v <= o_pop;
            if (out_free) r_o_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pa1 <= i_op.a1 * i_op.gx;
            r_pb1 <= i_op.b1 * i_op.gy;
            r_pa2 <= i_op.a2 * i_op.gx;
            r_pb2 <= i_op.b2 * i_op.gy;
            r_b_exam <= i_op.examine;
            r_b_zero <= i_op.zero;
            r_b_last <= i_op.last;
        end
        if (out_free && r_b_v) begin
            r_o.edge_label <= label;
            r_o.frame_end  <= r_b_last;
        end
    end

    assign o_valid = r_o_v;
    assign o_out   = r_o;
endmodule

FILE: design/gradient_non_max_suppression.sv
// Top level of the Canny non-maximum suppression block.
//   channel | signals                        | moves
//   in      | i_valid / o_ready / i_in       | one pixel or pad word
//   out     | o_valid / i_ready / o_out      | one label word
//   cfg     | i_cfg_we / i_cfg_idx / i_cfg_data | frame_cols, frame_rows
// One word per cycle sustained while i_ready stays high; the word that causes a
// label passes store read, window shift, operand select, products, output reg.
// The word is a row plus one pixel behind its pixel; pad words flush the tail.
// Reset is synchronous, active low; line stores are not cleared.
// o_ready drops only when the 8-entry queue cannot hold the words in flight.
`timescale 1ns / 1ps
module gradient_non_max_suppression (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  gnms_pkg::t_gnms_in         i_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output gnms_pkg::t_gnms_out        o_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [gnms_pkg::CFG_W-1:0] i_cfg_data
);
    import gnms_pkg::*;

    logic [CFG_COLS_W-1:0] r_frame_cols;
    logic [CFG_ROWS_W-1:0] r_frame_rows;
    logic       push, pop, q_valid;
    t_gnms_op   f_op, q_op;
    logic [Q_CW-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols <= CFG_COLS_W'(640);
            r_frame_rows <= CFG_ROWS_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_COLS: r_frame_cols <= i_cfg_data[CFG_COLS_W-1:0];
                CFG_IDX_ROWS: r_frame_rows <= i_cfg_data[CFG_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // room for this word plus the two still in the front pipeline
    assign o_ready = (q_count < Q_CW'(Q_DEPTH - 2));

    gnms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (i_valid && o_ready),
        .i_in         (i_in),
        .i_frame_cols (r_frame_cols),
        .i_frame_rows (r_frame_rows),
        .o_push       (push),
        .o_op         (f_op)
    );

    gnms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_count (q_count)
    );

    gnms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );
endmodule
